// File: hdl/ansp_pkg.sv
// Shared types, header codes and helpers for the Annex-B NAL unit splitter.
package ansp_pkg;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } t_in_payload;

    typedef struct packed {
        logic        status;
        logic [15:0] unit_offset;
        logic [15:0] unit_length;
        logic [7:0]  unit_header;
        logic [1:0]  unit_kind;
        logic [2:0]  code_size;
        logic        buffer_done;
    } t_out_payload;

    // Input stage toward the scanner
    typedef struct packed {
        logic        valid;
        t_in_payload beat;
    } t_stage;

    localparam logic [7:0] HDR_SPS = 8'h67;
    localparam logic [7:0] HDR_PPS = 8'h68;

    localparam logic [1:0] KIND_OTHER = 2'd0;
    localparam logic [1:0] KIND_SPS   = 2'd1;
    localparam logic [1:0] KIND_PPS   = 2'd2;

    localparam logic ST_UNIT  = 1'b0;
    localparam logic ST_ERROR = 1'b1;

    function automatic logic [1:0] kind_of(input logic [7:0] hdr);
        logic [1:0] k;
        k = KIND_OTHER;
        if (hdr == HDR_SPS) k = KIND_SPS;
        if (hdr == HDR_PPS) k = KIND_PPS;
        return k;
    endfunction

    function automatic t_out_payload error_result();
        t_out_payload r;
        r             = '0;
        r.status      = ST_ERROR;
        r.buffer_done = 1'b1;
        return r;
    endfunction

endpackage

// File: hdl/ansp_ifs.sv
// Valid/ready stream interfaces for byte input and unit report output.
interface ansp_in_if ();
    logic                  valid;
    logic                  ready;
    ansp_pkg::t_in_payload payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface ansp_out_if ();
    logic                   valid;
    logic                   ready;
    ansp_pkg::t_out_payload payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// File: hdl/ansp_in_stage.sv
// Input register: holds one byte beat until the scanner takes it.
module ansp_in_stage (
    input  logic             i_clk,
    input  logic             i_rst_n,
    ansp_in_if.sink          i_in,
    input  logic             i_take,
    output ansp_pkg::t_stage o_stage
);

    logic                  r_valid;
    ansp_pkg::t_in_payload r_beat;

    assign i_in.ready    = ~r_valid | i_take;
    assign o_stage.valid = r_valid;
    assign o_stage.beat  = r_beat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_in.valid && i_in.ready) begin
            r_valid <= 1'b1;
        end else if (i_take) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_beat <= i_in.payload;
        end
    end

endmodule

// File: hdl/ansp_scanner.sv
// Start code scanner: per-buffer state, unit length math and result register.
module ansp_scanner #(
    parameter int MAX_BUFFER_BYTES = 65536
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_wr_en,
    input  logic             i_cfg_wr_data,
    input  ansp_pkg::t_stage i_stage,
    output logic             o_take,
    ansp_out_if.source       o_out
);

    localparam int         PW   = $clog2(MAX_BUFFER_BYTES);
    localparam logic [PW:0] MAXB = (PW + 1)'(MAX_BUFFER_BYTES);

    typedef enum logic [1:0] {
        PH_LEAD,
        PH_HEAD,
        PH_BODY,
        PH_DROP
    } t_phase;

    t_phase     r_phase, n_phase;
    logic [PW-1:0] r_pos, n_pos;
    logic [PW-1:0] r_begin, n_begin;
    logic [1:0] r_zr, n_zr;
    logic [7:0] r_hdr, n_hdr;
    logic [2:0] r_lead, n_lead;
    logic       r_seen, n_seen;
    logic       r_stop_cfg;

    logic                   r_out_valid;
    ansp_pkg::t_out_payload r_out;
    ansp_pkg::t_out_payload res;
    logic                   emit;

    logic [7:0] b;
    logic       last;
    logic [PW:0] pos_inc;
    logic [PW:0] diff_raw, diff;
    logic [PW:0] len_code_raw, len_code;
    logic [PW:0] len_end_raw, len_end;
    logic [1:0]  hdr_kind;
    logic        pps_now;
    logic        stop;

    assign b    = i_stage.beat.data_byte;
    assign last = i_stage.beat.last_byte;

    assign o_take        = i_stage.valid & (~r_out_valid | o_out.ready);
    assign o_out.valid   = r_out_valid;
    assign o_out.payload = r_out;

    // Offsets wrap at the buffer size; each step is one add and a fixup.
    always_comb begin
        pos_inc  = {1'b0, r_pos} + (PW + 1)'(1);
        diff_raw = {1'b0, r_pos} - {1'b0, r_begin};
        diff     = diff_raw[PW] ? diff_raw + MAXB : diff_raw;
        len_code_raw = diff - (PW + 1)'(r_zr);
        len_code     = len_code_raw[PW] ? len_code_raw + MAXB : len_code_raw;
        len_end_raw  = diff + (PW + 1)'(1);
        len_end      = (len_end_raw == MAXB) ? '0 : len_end_raw;
    end

    assign hdr_kind = ansp_pkg::kind_of(r_hdr);
    assign pps_now  = r_seen | (hdr_kind == ansp_pkg::KIND_PPS);
    assign stop     = r_stop_cfg & pps_now;

    always_comb begin
        n_phase = r_phase;
        n_begin = r_begin;
        n_zr    = r_zr;
        n_hdr   = r_hdr;
        n_lead  = r_lead;
        n_seen  = r_seen;
        emit    = 1'b0;
        res     = '0;
        case (r_phase)
            PH_LEAD: begin
                if (b == 8'h00 && r_zr != 2'd3 && !last) begin
                    n_zr = r_zr + 2'd1;
                end else if (b == 8'h01 && r_zr >= 2'd2 && !last) begin
                    n_lead  = {1'b0, r_zr} + 3'd1;
                    n_phase = PH_HEAD;
                end else begin
                    emit    = 1'b1;
                    res     = ansp_pkg::error_result();
                    n_phase = PH_DROP;
                end
            end
            PH_HEAD: begin
                if (b[7]) begin
                    // forbidden bit set
                    emit    = 1'b1;
                    res     = ansp_pkg::error_result();
                    n_phase = PH_DROP;
                end else begin
                    n_hdr   = b;
                    n_begin = r_pos;
                    n_zr    = (b == 8'h00) ? 2'd1 : 2'd0;
                    n_phase = PH_BODY;
                    if (last) begin
                        emit            = 1'b1;
                        res.status      = ansp_pkg::ST_UNIT;
                        res.unit_offset = 16'(r_pos);
                        res.unit_length = 16'd1;
                        res.unit_header = b;
                        res.unit_kind   = ansp_pkg::kind_of(b);
                        res.code_size   = r_lead;
                        res.buffer_done = 1'b1;
                    end
                end
            end
            PH_BODY: begin
                if (b == 8'h01 && r_zr >= 2'd2) begin
                    emit            = 1'b1;
                    n_seen          = pps_now;
                    res.unit_offset = 16'(r_begin);
                    res.unit_length = 16'(len_code);
                    res.unit_header = r_hdr;
                    res.unit_kind   = hdr_kind;
                    res.code_size   = r_lead;
                    if (stop) begin
                        res.status      = ansp_pkg::ST_UNIT;
                        res.buffer_done = 1'b1;
                        n_phase         = PH_DROP;
                    end else if (last) begin
                        // start code on the final byte: next header is missing
                        res.status      = ansp_pkg::ST_ERROR;
                        res.buffer_done = 1'b1;
                    end else begin
                        res.status      = ansp_pkg::ST_UNIT;
                        res.buffer_done = 1'b0;
                        n_phase         = PH_HEAD;
                    end
                    n_lead = {1'b0, r_zr} + 3'd1;
                    n_zr   = 2'd0;
                end else begin
                    if (b == 8'h00) begin
                        if (r_zr != 2'd3) n_zr = r_zr + 2'd1;
                    end else begin
                        n_zr = 2'd0;
                    end
                    if (last) begin
                        emit            = 1'b1;
                        res.status      = ansp_pkg::ST_UNIT;
                        res.unit_offset = 16'(r_begin);
                        res.unit_length = 16'(len_end);
                        res.unit_header = r_hdr;
                        res.unit_kind   = hdr_kind;
                        res.code_size   = r_lead;
                        res.buffer_done = 1'b1;
                    end
                end
            end
            default: ;
        endcase

        if (last) begin
            n_phase = PH_LEAD;
            n_pos   = '0;
            n_begin = '0;
            n_zr    = 2'd0;
            n_hdr   = 8'h00;
            n_lead  = 3'd0;
            n_seen  = 1'b0;
        end else begin
            n_pos = (pos_inc == MAXB) ? '0 : pos_inc[PW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_LEAD;
            r_pos       <= '0;
            r_begin     <= '0;
            r_zr        <= 2'd0;
            r_hdr       <= 8'h00;
            r_lead      <= 3'd0;
            r_seen      <= 1'b0;
            r_stop_cfg  <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_stop_cfg <= i_cfg_wr_data;
            end
            if (o_take) begin
                r_phase <= n_phase;
                r_pos   <= n_pos;
                r_begin <= n_begin;
                r_zr    <= n_zr;
                r_hdr   <= n_hdr;
                r_lead  <= n_lead;
                r_seen  <= n_seen;
            end
            if (o_take && emit) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take && emit) begin
            r_out <= res;
        end
    end

endmodule

// File: hdl/annexb_nal_unit_splitter_unit.sv
// Top level of the Annex-B NAL unit splitter.
//
// i_in carries one buffer byte per beat, last_byte set on the buffer's final
// byte. o_out carries one report per NAL unit found (offset, length, header,
// kind, start code size; error status if a start code on the final byte
// closes it), or one error report when the buffer does not open with a valid
// start code and header, or a header's forbidden bit is set. buffer_done
// marks the buffer's last report. i_cfg_wr_en / i_cfg_wr_data write
// stop_after_pps (reset 1), which drops the rest of a buffer once a PPS unit
// was reported; write it only while no bytes are in flight. Throughput: one
// byte per cycle while o_out does not stall, set by the single scan stage
// between the input register and the result register. When o_out stalls, the
// result register holds its report and the input register still takes one
// more byte; a further byte waits until the report is taken. Reset
// (synchronous, active low) empties both registers, clears the per-buffer
// scan state and sets stop_after_pps to 1. Offsets wrap at MAX_BUFFER_BYTES
// and are reported in 16 bits.
module annexb_nal_unit_splitter_unit #(
    parameter int MAX_BUFFER_BYTES = 65536
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_wr_en,
    input  logic       i_cfg_wr_data,
    ansp_in_if.sink    i_in,
    ansp_out_if.source o_out
);

    ansp_pkg::t_stage stage;
    logic             take;

    ansp_in_stage u_in_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_take  (take),
        .o_stage (stage)
    );

    ansp_scanner #(
        .MAX_BUFFER_BYTES (MAX_BUFFER_BYTES)
    ) u_scanner (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_stage       (stage),
        .o_take        (take),
        .o_out         (o_out)
    );

endmodule

// File: bench/tb.sv
// Self-checking testbench for the Annex-B NAL unit splitter: directed table, random buffers.
`timescale 1ns / 1ps

module tb;
    import ansp_pkg::*;

    localparam int          DRAIN_CYCLES = 8;
    localparam int          DRAIN_LIMIT  = 4000;
    localparam int unsigned CYCLE_LIMIT  = 3_000_000;

    typedef enum logic [1:0] {SCAN_LEAD, SCAN_HEAD, SCAN_BODY, SCAN_DROP} t_scan_phase;

    typedef struct packed {
        logic [7:0]   data;
        logic         fin;
        logic         typed;
        t_out_payload want;
    } t_dir_row;

    localparam t_out_payload NO_UNIT  = '0;
    localparam t_out_payload ERR_UNIT = {ST_ERROR, 16'd0, 16'd0, 8'd0, KIND_OTHER, 3'd0, 1'b1};
    // header byte is the final byte, after a 4-byte start code
    localparam t_out_payload HDR_LAST_UNIT = {ST_UNIT, 16'd4, 16'd1, 8'h7F, KIND_OTHER, 3'd4,
                                              1'b1};

    localparam int N_DIR = 28;
    localparam t_dir_row DIR_ROWS [N_DIR] = '{
        // four leading zeros, last one ends the buffer
        {8'h00, 1'b0, 1'b0, NO_UNIT},
        {8'h00, 1'b0, 1'b0, NO_UNIT},
        {8'h00, 1'b0, 1'b0, NO_UNIT},
        {8'h00, 1'b1, 1'b1, ERR_UNIT},
        // buffer ends on the start code, before any header
        {8'h00, 1'b0, 1'b0, NO_UNIT},
        {8'h00, 1'b0, 1'b0, NO_UNIT},
        {8'h01, 1'b1, 1'b1, ERR_UNIT},
        // forbidden bit set in the header
        {8'h00, 1'b0, 1'b0, NO_UNIT},
        {8'h00, 1'b0, 1'b0, NO_UNIT},
        {8'h01, 1'b0, 1'b0, NO_UNIT},
        {8'h80, 1'b1, 1'b1, ERR_UNIT},
        // header as the final byte
        {8'h00, 1'b0, 1'b0, NO_UNIT},
        {8'h00, 1'b0, 1'b0, NO_UNIT},
        {8'h00, 1'b0, 1'b0, NO_UNIT},
        {8'h01, 1'b0, 1'b0, NO_UNIT},
        {8'h7F, 1'b1, 1'b1, HDR_LAST_UNIT},
        // SPS then PPS; the PPS is closed by a start code on the final byte
        {8'h00, 1'b0, 1'b0, NO_UNIT},
        {8'h00, 1'b0, 1'b0, NO_UNIT},
        {8'h01, 1'b0, 1'b0, NO_UNIT},
        {HDR_SPS, 1'b0, 1'b0, NO_UNIT},
        {8'hFF, 1'b0, 1'b0, NO_UNIT},
        {8'h00, 1'b0, 1'b0, NO_UNIT},
        {8'h00, 1'b0, 1'b0, NO_UNIT},
        {8'h01, 1'b0, 1'b0, NO_UNIT},
        {HDR_PPS, 1'b0, 1'b0, NO_UNIT},
        {8'h00, 1'b0, 1'b0, NO_UNIT},
        {8'h00, 1'b0, 1'b0, NO_UNIT},
        {8'h01, 1'b1, 1'b0, NO_UNIT}
    };

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic i_cfg_wr_en;
    logic i_cfg_wr_data;

    ansp_in_if  byte_if ();
    ansp_out_if unit_if ();

    annexb_nal_unit_splitter_unit i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_in          (byte_if),
        .o_out         (unit_if)
    );

    always #4 i_clk = ~i_clk;

    // scanner state mirrored by the predictor
    logic        pps_stop_mode;
    logic [15:0] scan_pos;
    logic [1:0]  zero_count;
    t_scan_phase phase_now;
    logic [15:0] unit_start;
    logic [7:0]  unit_hdr;
    logic [2:0]  code_len;
    logic        pps_seen;

    t_out_payload pending_units [$];
    logic [7:0]   buf_bytes [$];
    int           mismatch_count = 0;
    int           units_seen     = 0;
    int           beats_sent     = 0;
    int           burst_left     = 0;
    int unsigned  cycle_count    = 0;

    task automatic report_mismatch(input string msg);
        mismatch_count++;
        $display("MISMATCH at %0t ns, unit %0d: %s", $time, units_seen, msg);
    endtask

    task automatic compare_field(input string name, input logic [15:0] got,
                                 input logic [15:0] want);
        if (got !== want) begin
            report_mismatch($sformatf("%s got %h want %h", name, got, want));
        end
    endtask

    function automatic logic [1:0] unit_kind_for(input logic [7:0] hdr);
        if (hdr == HDR_SPS) return KIND_SPS;
        if (hdr == HDR_PPS) return KIND_PPS;
        return KIND_OTHER;
    endfunction

    task automatic clear_scan_state();
        scan_pos   = '0;
        zero_count = '0;
        phase_now  = SCAN_LEAD;
        unit_start = '0;
        unit_hdr   = '0;
        code_len   = '0;
        pps_seen   = 1'b0;
    endtask

    task automatic predict_byte(input t_in_payload beat, output logic emit,
                                output t_out_payload unit);
        logic [7:0] b;
        logic       fin;
        logic       halt;
        logic [1:0] kind;
        b    = beat.data_byte;
        fin  = beat.last_byte;
        emit = 1'b0;
        unit = '0;
        case (phase_now)
            SCAN_LEAD: begin
                if (b == 8'h00 && zero_count != 2'd3 && !fin) begin
                    zero_count = zero_count + 2'd1;
                end else if (b == 8'h01 && zero_count >= 2'd2 && !fin) begin
                    code_len  = {1'b0, zero_count} + 3'd1;
                    phase_now = SCAN_HEAD;
                end else begin
                    unit      = ERR_UNIT;
                    emit      = 1'b1;
                    phase_now = SCAN_DROP;
                end
            end
            SCAN_HEAD: begin
                if (b[7]) begin
                    unit      = ERR_UNIT;
                    emit      = 1'b1;
                    phase_now = SCAN_DROP;
                end else begin
                    unit_hdr   = b;
                    unit_start = scan_pos;
                    zero_count = (b == 8'h00) ? 2'd1 : 2'd0;
                    phase_now  = SCAN_BODY;
                    if (fin) begin
                        unit = {ST_UNIT, scan_pos, 16'd1, b, unit_kind_for(b), code_len, 1'b1};
                        emit = 1'b1;
                    end
                end
            end
            SCAN_BODY: begin
                if (b == 8'h01 && zero_count >= 2'd2) begin
                    kind = unit_kind_for(unit_hdr);
                    if (kind == KIND_PPS) pps_seen = 1'b1;
                    halt = pps_stop_mode && pps_seen;
                    // a start code on the final byte leaves the next unit headerless
                    unit.status      = (fin && !halt) ? ST_ERROR : ST_UNIT;
                    unit.unit_offset = unit_start;
                    unit.unit_length = scan_pos - unit_start - {14'd0, zero_count};
                    unit.unit_header = unit_hdr;
                    unit.unit_kind   = kind;
                    unit.code_size   = code_len;
                    unit.buffer_done = halt || fin;
                    emit = 1'b1;
                    if (halt) begin
                        phase_now = SCAN_DROP;
                    end else if (!fin) begin
                        phase_now = SCAN_HEAD;
                    end
                    code_len   = {1'b0, zero_count} + 3'd1;
                    zero_count = '0;
                end else begin
                    if (b == 8'h00) begin
                        if (zero_count != 2'd3) zero_count = zero_count + 2'd1;
                    end else begin
                        zero_count = '0;
                    end
                    // trailing zeros stay in the length at the buffer's end
                    if (fin) begin
                        unit = {ST_UNIT, unit_start, scan_pos + 16'd1 - unit_start, unit_hdr,
                                unit_kind_for(unit_hdr), code_len, 1'b1};
                        emit = 1'b1;
                    end
                end
            end
            default: ;
        endcase
        if (fin) begin
            clear_scan_state();
        end else begin
            scan_pos = scan_pos + 16'd1;
        end
    endtask

    // Drives one beat in a burst/gap pattern and records what it should cause.
    task automatic send_beat(input logic [7:0] data, input logic fin, input logic typed,
                             input t_out_payload want);
        t_in_payload  beat;
        t_out_payload unit;
        logic         emit;
        if (burst_left == 0) begin
            byte_if.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                     : $urandom_range(1, 24);
        end
        burst_left--;
        beat.data_byte  = data;
        beat.last_byte  = fin;
        byte_if.valid   <= 1'b1;
        byte_if.payload <= beat;
        @(posedge i_clk);
        while (!byte_if.ready) @(posedge i_clk);
        beats_sent++;
        predict_byte(beat, emit, unit);
        if (typed) begin
            unit = want;
            emit = 1'b1;
        end
        if (emit) pending_units.push_back(unit);
    endtask

    task automatic wait_units_drained(input logic settle);
        byte_if.valid <= 1'b0;
        burst_left = 0;
        while (pending_units.size() != 0) @(posedge i_clk);
        if (settle) repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_stop_mode(input logic value);
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= value;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        pps_stop_mode = value;
    endtask

    task automatic send_buffer();
        int k;
        for (k = 0; k < buf_bytes.size(); k++) begin
            send_beat(buf_bytes[k], k == buf_bytes.size() - 1, 1'b0, NO_UNIT);
        end
        buf_bytes.delete();
    endtask

    task automatic push_start_code();
        repeat ($urandom_range(2, 3)) buf_bytes.push_back(8'h00);
        buf_bytes.push_back(8'h01);
    endtask

    function automatic logic [7:0] random_header();
        int sel;
        sel = $urandom_range(0, 19);
        if (sel < 5) return HDR_SPS;
        if (sel < 10) return HDR_PPS;
        if (sel == 10) return 8'h00;
        if (sel == 11) return 8'($urandom_range(128, 255));
        return 8'($urandom_range(0, 127));
    endfunction

    // zero-heavy so that stray start codes and emulation bytes show up in bodies
    function automatic logic [7:0] body_byte();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel < 3) return 8'h00;
        if (sel == 3) return 8'h01;
        if (sel == 4) return 8'h03;
        return 8'($urandom_range(0, 255));
    endfunction

    task automatic run_random_phase(input int n_beats);
        int stop_at;
        int n_units;
        int u;
        stop_at = beats_sent + n_beats;
        while (beats_sent < stop_at) begin
            if ($urandom_range(0, 4) != 0) begin
                push_start_code();
                n_units = $urandom_range(1, 5);
                for (u = 0; u < n_units; u++) begin
                    buf_bytes.push_back(random_header());
                    repeat ($urandom_range(0, 10)) buf_bytes.push_back(body_byte());
                    if (u != n_units - 1) push_start_code();
                end
                case ($urandom_range(0, 3))
                    1: repeat ($urandom_range(1, 3)) buf_bytes.push_back(8'h00);
                    2: push_start_code();
                    3: begin
                        push_start_code();
                        buf_bytes.push_back(random_header());
                    end
                    default: ;
                endcase
            end else begin
                case ($urandom_range(0, 4))
                    0: repeat ($urandom_range(1, 8)) buf_bytes.push_back(8'($urandom_range(0, 255)));
                    1: begin
                        buf_bytes.push_back(8'h00);
                        buf_bytes.push_back(8'h01);
                    end
                    2: repeat (4) buf_bytes.push_back(8'h00);
                    3: begin
                        buf_bytes.push_back(8'h00);
                        buf_bytes.push_back(8'h00);
                        buf_bytes.push_back(8'($urandom_range(2, 255)));
                    end
                    default: begin
                        buf_bytes.push_back(8'h00);
                        buf_bytes.push_back(8'h00);
                        buf_bytes.push_back(8'h01);
                        buf_bytes.push_back(8'($urandom_range(128, 255)));
                    end
                endcase
                repeat ($urandom_range(0, 4)) buf_bytes.push_back(body_byte());
            end
            send_buffer();
            if ($urandom_range(0, 39) == 0) wait_units_drained(1'b0);
        end
    endtask

    task automatic check_unit(input t_out_payload got);
        t_out_payload want;
        if (pending_units.size() == 0) begin
            report_mismatch($sformatf("unexpected unit report %h", got));
        end else begin
            want = pending_units.pop_front();
            compare_field("status", got.status, want.status);
            compare_field("unit_offset", got.unit_offset, want.unit_offset);
            compare_field("unit_length", got.unit_length, want.unit_length);
            compare_field("unit_header", got.unit_header, want.unit_header);
            compare_field("unit_kind", got.unit_kind, want.unit_kind);
            compare_field("code_size", got.code_size, want.code_size);
            compare_field("buffer_done", got.buffer_done, want.buffer_done);
        end
        units_seen++;
    endtask

    // receiver: checks accepted reports, stall pattern shifts with cycle_count[9:8]
    always @(posedge i_clk) begin
        if (i_rst_n && unit_if.valid && unit_if.ready) check_unit(unit_if.payload);
        case (cycle_count[9:8])
            2'd0: unit_if.ready <= 1'b1;
            2'd1: unit_if.ready <= 1'($urandom_range(0, 1));
            2'd2: unit_if.ready <= ($urandom_range(0, 15) == 0);
            default: unit_if.ready <= (cycle_count[2:0] != 3'd0);
        endcase
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("annexb_nal_unit_splitter_unit test failed");
            $finish;
        end
    end

    initial begin
        int i;
        int drain;
        i_rst_n         = 1'b0;
        i_cfg_wr_en     = 1'b0;
        i_cfg_wr_data   = 1'b0;
        byte_if.valid   = 1'b0;
        byte_if.payload = '0;
        pps_stop_mode   = 1'b1;
        clear_scan_state();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (i = 0; i < N_DIR; i++) begin
            send_beat(DIR_ROWS[i].data, DIR_ROWS[i].fin, DIR_ROWS[i].typed, DIR_ROWS[i].want);
        end
        wait_units_drained(1'b1);

        run_random_phase(500);
        wait_units_drained(1'b1);
        write_stop_mode(1'b0);
        run_random_phase(500);
        wait_units_drained(1'b1);
        write_stop_mode(1'b1);
        run_random_phase(450);
        wait_units_drained(1'b1);
        write_stop_mode(1'b0);
        run_random_phase(450);

        byte_if.valid <= 1'b0;
        drain = 0;
        while (pending_units.size() != 0 && drain < DRAIN_LIMIT) begin
            @(posedge i_clk);
            drain++;
        end
        if (pending_units.size() != 0) begin
            report_mismatch($sformatf("%0d expected units never arrived", pending_units.size()));
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("annexb_nal_unit_splitter_unit test passed");
        end else begin
            $display("annexb_nal_unit_splitter_unit test failed");
        end
        $finish;
    end

endmodule

// File: files.f
hdl/ansp_pkg.sv
hdl/ansp_ifs.sv
hdl/ansp_in_stage.sv
hdl/ansp_scanner.sv
hdl/annexb_nal_unit_splitter_unit.sv
bench/tb.sv
